// ===== hw/rtl/tm_pkg.sv =====
`timescale 1ns / 1ps

package tm_pkg;

   localparam int StickW     = 8;
   localparam int GainW      = 10;
   localparam int CutW       = 7;
   localparam int PulseW     = 12;
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 12;

   localparam int Lanes      = 4;
   localparam int Motors     = Lanes + 1;
   localparam int VertLane   = Lanes;

   localparam int MagW       = 8;
   localparam int SqW        = 16;
   localparam int TermW      = 26;
   localparam int NW         = 27;
   localparam int RemW       = 26;
   localparam int SumW       = 9;
   localparam int QuotBits   = 9;
   localparam int PctShift   = 8;
   localparam int PctW       = 8;
   localparam int PctMagW    = 7;
   localparam int PctLimit   = 100;
   localparam int PctScale   = 1 << PctShift;

   localparam int ProdW      = 22;
   localparam int DivPreSh   = 3;
   localparam int DivInW     = 17;
   localparam int RecipW     = 18;
   localparam int Recip      = 167773;
   localparam int RecipShift = 22;
   localparam int RecipProdW = DivInW + RecipW;
   localparam int PulseSumW  = PulseW + 2;
   localparam int PulseTop   = (1 << PulseW) - 1;
   localparam int PulseLat   = 3;

   localparam logic [GainW-1:0]  GainReset    = GainW'(256);
   localparam logic [CutW-1:0]   CutReset     = '0;
   localparam logic [PulseW-1:0] PulseMinRst  = PulseW'(1000);
   localparam logic [PulseW-1:0] PulseMaxRst  = PulseW'(2000);
   localparam logic [PulseW-1:0] PulseNeuRst  = PulseW'(1500);

   // negative sign per horizontal lane: front left, front right, back left, back right
   localparam logic [Lanes-1:0] NegForward  = 4'b1010;
   localparam logic [Lanes-1:0] NegSideways = 4'b0011;
   localparam logic [Lanes-1:0] NegRotation = 4'b1001;

   typedef enum logic [CsrIndexW-1:0] {
      RegGainForward  = 3'd0,
      RegGainSideways = 3'd1,
      RegGainRotation = 3'd2,
      RegZeroCutoff   = 3'd3,
      RegPulseMin     = 3'd4,
      RegPulseMax     = 3'd5,
      RegPulseNeutral = 3'd6,
      RegSuspend      = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic signed [StickW-1:0] vert;
      logic [Lanes-1:0]         neg;
      logic [Lanes-1:0]         nz;
      logic                     szero;
   } tag_type;

endpackage

// ===== hw/rtl/thruster_mixer.sv =====
`timescale 1ns / 1ps

// Channel   Ports                                  Handshake
// item in   req_stick_*                            start & !busy
// result    rsp_pulse_*, rsp_light_on              rsp_strobe, one cycle
// config    csr_index, csr_wdata                   csr_we
//
// One item per cycle while busy is low; each item taken passes through
// four mixing stages, nine restoring divider steps (one quotient bit each),
// one limit stage and three pulse mapping stages.
// Reset is synchronous; busy is high for the cycle after reset.
// The receiver cannot stall, so the pipeline advances every cycle.

module thruster_mixer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [tm_pkg::StickW-1:0]     req_stick_vertical,
   input  logic signed [tm_pkg::StickW-1:0]     req_stick_rotation,
   input  logic signed [tm_pkg::StickW-1:0]     req_stick_sideways,
   input  logic signed [tm_pkg::StickW-1:0]     req_stick_forward,
   input  logic                                 csr_we,
   input  logic [tm_pkg::CsrIndexW-1:0]         csr_index,
   input  logic [tm_pkg::CsrDataW-1:0]          csr_wdata,
   output logic                                 rsp_strobe,
   output logic [tm_pkg::PulseW-1:0]            rsp_pulse_front_left,
   output logic [tm_pkg::PulseW-1:0]            rsp_pulse_front_right,
   output logic [tm_pkg::PulseW-1:0]            rsp_pulse_back_left,
   output logic [tm_pkg::PulseW-1:0]            rsp_pulse_back_right,
   output logic [tm_pkg::PulseW-1:0]            rsp_pulse_vertical_a,
   output logic [tm_pkg::PulseW-1:0]            rsp_pulse_vertical_b,
   output logic                                 rsp_light_on
);

   localparam int StickW = tm_pkg::StickW;
   localparam int GainW  = tm_pkg::GainW;
   localparam int CutW   = tm_pkg::CutW;
   localparam int PulseW = tm_pkg::PulseW;
   localparam int Lanes  = tm_pkg::Lanes;
   localparam int Motors = tm_pkg::Motors;
   localparam int SqW    = tm_pkg::SqW;
   localparam int TermW  = tm_pkg::TermW;
   localparam int NW     = tm_pkg::NW;
   localparam int RemW   = tm_pkg::RemW;
   localparam int SumW   = tm_pkg::SumW;
   localparam int MagW   = tm_pkg::MagW;
   localparam int PctW   = tm_pkg::PctW;
   localparam int PMW    = tm_pkg::PctMagW;
   localparam int QB     = tm_pkg::QuotBits;
   localparam int PLat   = tm_pkg::PulseLat;

   logic                busy_ff;
   logic                accept;

   logic [GainW-1:0]    gain_fwd_ff;
   logic [GainW-1:0]    gain_side_ff;
   logic [GainW-1:0]    gain_rot_ff;
   logic [CutW-1:0]     cutoff_ff;
   logic [PulseW-1:0]   pmin_ff;
   logic [PulseW-1:0]   pmax_ff;
   logic [PulseW-1:0]   pneu_ff;
   logic                suspend_ff;

   logic                        v1_ff;
   logic signed [StickW-1:0]    st_v1_ff, st_r1_ff, st_s1_ff, st_f1_ff;

   logic [MagW-1:0]             mag_r, mag_s, mag_f;
   logic signed [SqW-1:0]       sq_r_in, sq_s_in, sq_f_in;
   logic [SumW-1:0]             sum2_in;
   logic                        v2_ff;
   logic signed [SqW-1:0]       sq_r2_ff, sq_s2_ff, sq_f2_ff;
   logic [SumW-1:0]             sum2_ff;
   logic signed [StickW-1:0]    vert2_ff;

   logic signed [TermW-1:0]     t_r_in, t_s_in, t_f_in;
   logic                        v3_ff;
   logic signed [TermW-1:0]     t_r3_ff, t_s3_ff, t_f3_ff;
   logic [SumW-1:0]             sum3_ff;
   logic signed [StickW-1:0]    vert3_ff;

   logic [Lanes-1:0][RemW-1:0]  abs4_in;
   tm_pkg::tag_type             tag4_in;
   logic                        v4_ff;
   logic [Lanes-1:0][RemW-1:0]  abs4_ff;
   logic [SumW-1:0]             sum4_ff;
   tm_pkg::tag_type             tag4_ff;

   logic                        dv_valid;
   logic [Lanes-1:0][QB-1:0]    dv_quot;
   tm_pkg::tag_type             dv_tag;

   logic [Motors-1:0][PctW-1:0] pct5_in;
   logic                        light5_in;
   logic                        v5_ff;
   logic [Motors-1:0][PctW-1:0] pct5_ff;
   logic                        light5_ff;

   logic [PLat-1:0]             vp_ff;
   logic [PLat-1:0]             lp_ff;
   logic [PulseW-1:0]           pulse_out [Motors];

   assign busy   = busy_ff;
   assign accept = start & ~busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         gain_fwd_ff  <= tm_pkg::GainReset;
         gain_side_ff <= tm_pkg::GainReset;
         gain_rot_ff  <= tm_pkg::GainReset;
         cutoff_ff    <= tm_pkg::CutReset;
         pmin_ff      <= tm_pkg::PulseMinRst;
         pmax_ff      <= tm_pkg::PulseMaxRst;
         pneu_ff      <= tm_pkg::PulseNeuRst;
         suspend_ff   <= 1'b0;
      end else begin
         busy_ff <= 1'b0;
         if (csr_we) begin
            unique case (tm_pkg::reg_index_type'(csr_index))
               tm_pkg::RegGainForward:  gain_fwd_ff  <= csr_wdata[GainW-1:0];
               tm_pkg::RegGainSideways: gain_side_ff <= csr_wdata[GainW-1:0];
               tm_pkg::RegGainRotation: gain_rot_ff  <= csr_wdata[GainW-1:0];
               tm_pkg::RegZeroCutoff:   cutoff_ff    <= csr_wdata[CutW-1:0];
               tm_pkg::RegPulseMin:     pmin_ff      <= csr_wdata[PulseW-1:0];
               tm_pkg::RegPulseMax:     pmax_ff      <= csr_wdata[PulseW-1:0];
               tm_pkg::RegPulseNeutral: pneu_ff      <= csr_wdata[PulseW-1:0];
               tm_pkg::RegSuspend:      suspend_ff   <= csr_wdata[0];
               default:                 suspend_ff   <= suspend_ff;
            endcase
         end
      end
   end

   // magnitudes, signed squares and magnitude sum
   always_comb begin
      logic signed [SqW-1:0] ev, em;
      mag_r = st_r1_ff[StickW-1] ? MagW'(-st_r1_ff) : MagW'(st_r1_ff);
      mag_s = st_s1_ff[StickW-1] ? MagW'(-st_s1_ff) : MagW'(st_s1_ff);
      mag_f = st_f1_ff[StickW-1] ? MagW'(-st_f1_ff) : MagW'(st_f1_ff);
      ev = {{(SqW-StickW){st_r1_ff[StickW-1]}}, st_r1_ff};
      em = {{(SqW-MagW){1'b0}}, mag_r};
      sq_r_in = ev * em;
      ev = {{(SqW-StickW){st_s1_ff[StickW-1]}}, st_s1_ff};
      em = {{(SqW-MagW){1'b0}}, mag_s};
      sq_s_in = ev * em;
      ev = {{(SqW-StickW){st_f1_ff[StickW-1]}}, st_f1_ff};
      em = {{(SqW-MagW){1'b0}}, mag_f};
      sq_f_in = ev * em;
      sum2_in = SumW'(mag_r) + SumW'(mag_s) + SumW'(mag_f);
   end

   // gain terms
   always_comb begin
      logic signed [TermW-1:0] es, eg;
      es = {{(TermW-SqW){sq_r2_ff[SqW-1]}}, sq_r2_ff};
      eg = {{(TermW-GainW){1'b0}}, gain_rot_ff};
      t_r_in = es * eg;
      es = {{(TermW-SqW){sq_s2_ff[SqW-1]}}, sq_s2_ff};
      eg = {{(TermW-GainW){1'b0}}, gain_side_ff};
      t_s_in = es * eg;
      es = {{(TermW-SqW){sq_f2_ff[SqW-1]}}, sq_f2_ff};
      eg = {{(TermW-GainW){1'b0}}, gain_fwd_ff};
      t_f_in = es * eg;
   end

   // signed lane sums, split into magnitude and sign
   always_comb begin
      logic signed [NW-1:0] ef, es, er, n, nn;
      ef = {{(NW-TermW){t_f3_ff[TermW-1]}}, t_f3_ff};
      es = {{(NW-TermW){t_s3_ff[TermW-1]}}, t_s3_ff};
      er = {{(NW-TermW){t_r3_ff[TermW-1]}}, t_r3_ff};
      tag4_in.vert  = vert3_ff;
      tag4_in.szero = (sum3_ff == '0);
      for (int l = 0; l < Lanes; l++) begin
         n = (tm_pkg::NegForward[l]  ? -ef : ef)
           + (tm_pkg::NegSideways[l] ? -es : es)
           + (tm_pkg::NegRotation[l] ? -er : er);
         nn = -n;
         abs4_in[l] = n[NW-1] ? nn[RemW-1:0] : n[RemW-1:0];
         tag4_in.neg[l] = n[NW-1];
         tag4_in.nz[l]  = (abs4_in[l] > RemW'(1))
                        || (abs4_in[l] == RemW'(1) && sum3_ff <= SumW'(tm_pkg::PctScale));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         st_v1_ff <= req_stick_vertical;
         st_r1_ff <= req_stick_rotation;
         st_s1_ff <= req_stick_sideways;
         st_f1_ff <= req_stick_forward;
      end
      sq_r2_ff <= sq_r_in;
      sq_s2_ff <= sq_s_in;
      sq_f2_ff <= sq_f_in;
      sum2_ff  <= sum2_in;
      vert2_ff <= st_v1_ff;
      t_r3_ff  <= t_r_in;
      t_s3_ff  <= t_s_in;
      t_f3_ff  <= t_f_in;
      sum3_ff  <= sum2_ff;
      vert3_ff <= vert2_ff;
      abs4_ff  <= abs4_in;
      sum4_ff  <= sum3_ff;
      tag4_ff  <= tag4_in;
   end

   tm_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_rem    (abs4_ff),
      .in_sum    (sum4_ff),
      .in_tag    (tag4_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_tag   (dv_tag)
   );

   // clamp to full scale, apply cutoff, collect the light flag
   always_comb begin
      logic [PMW-1:0]           qc, pm;
      logic                     kill;
      logic signed [PctW-1:0]   vc, vm;
      light5_in = 1'b0;
      for (int l = 0; l < Lanes; l++) begin
         qc = (dv_quot[l] > QB'(tm_pkg::PctLimit)) ? PMW'(tm_pkg::PctLimit)
                                                   : dv_quot[l][PMW-1:0];
         kill = dv_tag.szero || (qc < cutoff_ff);
         pm = kill ? '0 : qc;
         pct5_in[l] = dv_tag.neg[l] ? PctW'(-{1'b0, pm}) : {1'b0, pm};
         light5_in = light5_in | (dv_tag.nz[l] & ~kill);
      end
      if (dv_tag.vert > $signed(PctW'(tm_pkg::PctLimit))) begin
         vc = PctW'(tm_pkg::PctLimit);
      end else if (dv_tag.vert < -$signed(PctW'(tm_pkg::PctLimit))) begin
         vc = -$signed(PctW'(tm_pkg::PctLimit));
      end else begin
         vc = dv_tag.vert;
      end
      vm = vc[PctW-1] ? -vc : vc;
      kill = (vm[PMW-1:0] < cutoff_ff);
      pct5_in[tm_pkg::VertLane] = kill ? '0 : vc;
      light5_in = light5_in | (~kill & (vc != '0));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         vp_ff <= '0;
      end else begin
         v5_ff <= dv_valid;
         vp_ff <= {vp_ff[PLat-2:0], v5_ff};
      end
   end

   always_ff @(posedge clock) begin
      pct5_ff   <= pct5_in;
      light5_ff <= light5_in;
      lp_ff     <= {lp_ff[PLat-2:0], light5_ff};
   end

   for (genvar m = 0; m < Motors; m++) begin : g_pulse
      tm_pulse u_pulse (
         .clock         (clock),
         .pct           ($signed(pct5_ff[m])),
         .pulse_min     (pmin_ff),
         .pulse_max     (pmax_ff),
         .pulse_neutral (pneu_ff),
         .suspend       (suspend_ff),
         .pulse         (pulse_out[m])
      );
   end

   assign rsp_strobe            = vp_ff[PLat-1];
   assign rsp_light_on          = lp_ff[PLat-1];
   assign rsp_pulse_front_left  = pulse_out[0];
   assign rsp_pulse_front_right = pulse_out[1];
   assign rsp_pulse_back_left   = pulse_out[2];
   assign rsp_pulse_back_right  = pulse_out[3];
   assign rsp_pulse_vertical_a  = pulse_out[tm_pkg::VertLane];
   assign rsp_pulse_vertical_b  = pulse_out[tm_pkg::VertLane];

endmodule

// ===== hw/rtl/tm_divider.sv =====
`timescale 1ns / 1ps

module tm_divider (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  logic [tm_pkg::Lanes-1:0][tm_pkg::RemW-1:0] in_rem,
   input  logic [tm_pkg::SumW-1:0]                   in_sum,
   input  tm_pkg::tag_type                           in_tag,
   output logic                                      out_valid,
   output logic [tm_pkg::Lanes-1:0][tm_pkg::QuotBits-1:0] out_quot,
   output tm_pkg::tag_type                           out_tag
);

   localparam int Steps = tm_pkg::QuotBits;
   localparam int Lanes = tm_pkg::Lanes;
   localparam int RemW  = tm_pkg::RemW;
   localparam int SumW  = tm_pkg::SumW;

   logic [Steps-1:0]                     valid_ff;
   logic [Lanes-1:0][RemW-1:0]           rem_ff  [Steps];
   logic [Lanes-1:0][Steps-1:0]          quot_ff [Steps];
   logic [SumW-1:0]                      sum_ff  [Steps];
   tm_pkg::tag_type                      tag_ff  [Steps];

   for (genvar j = 0; j < Steps; j++) begin : g_step
      localparam int Sh = tm_pkg::PctShift + Steps - 1 - j;
      logic                        valid_src;
      logic [Lanes-1:0][RemW-1:0]  rem_src;
      logic [Lanes-1:0][Steps-1:0] quot_src;
      logic [SumW-1:0]             sum_src;
      tm_pkg::tag_type             tag_src;
      logic [RemW-1:0]             dvs;

      if (j == 0) begin : g_first
         assign valid_src = in_valid;
         assign rem_src   = in_rem;
         assign quot_src  = '0;
         assign sum_src   = in_sum;
         assign tag_src   = in_tag;
      end else begin : g_next
         assign valid_src = valid_ff[j-1];
         assign rem_src   = rem_ff[j-1];
         assign quot_src  = quot_ff[j-1];
         assign sum_src   = sum_ff[j-1];
         assign tag_src   = tag_ff[j-1];
      end

      assign dvs = {{(RemW-SumW){1'b0}}, sum_src} << Sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else begin
            valid_ff[j] <= valid_src;
         end
      end

      always_ff @(posedge clock) begin
         sum_ff[j] <= sum_src;
         tag_ff[j] <= tag_src;
      end

      for (genvar l = 0; l < Lanes; l++) begin : g_lane
         logic [RemW:0] diff;
         assign diff = {1'b0, rem_src[l]} - {1'b0, dvs};
         always_ff @(posedge clock) begin
            rem_ff[j][l]  <= diff[RemW] ? rem_src[l] : diff[RemW-1:0];
            quot_ff[j][l] <= {quot_src[l][Steps-2:0], ~diff[RemW]};
         end
      end
   end

   assign out_valid = valid_ff[Steps-1];
   assign out_quot  = quot_ff[Steps-1];
   assign out_tag   = tag_ff[Steps-1];

endmodule

// ===== hw/rtl/tm_pulse.sv =====
`timescale 1ns / 1ps

module tm_pulse (
   input  logic                             clock,
   input  logic signed [tm_pkg::PctW-1:0]   pct,
   input  logic [tm_pkg::PulseW-1:0]        pulse_min,
   input  logic [tm_pkg::PulseW-1:0]        pulse_max,
   input  logic [tm_pkg::PulseW-1:0]        pulse_neutral,
   input  logic                             suspend,
   output logic [tm_pkg::PulseW-1:0]        pulse
);

   localparam int ProdW  = tm_pkg::ProdW;
   localparam int PulseW = tm_pkg::PulseW;
   localparam int SumW   = tm_pkg::PulseSumW;

   logic signed [ProdW-1:0]            pct_ext;
   logic signed [ProdW-1:0]            off;
   logic signed [ProdW-1:0]            span;
   logic signed [ProdW-1:0]            prod_in;
   logic signed [ProdW-1:0]            prod_ff;
   logic [ProdW-1:0]                   mag;
   logic [tm_pkg::DivInW-1:0]          x;
   logic [tm_pkg::RecipProdW-1:0]      y_in;
   logic [tm_pkg::RecipProdW-1:0]      y_ff;
   logic                               neg_ff;
   logic [PulseW-1:0]                  q;
   logic signed [SumW-1:0]             r;
   logic signed [SumW-1:0]             p;
   logic [PulseW-1:0]                  pulse_in;
   logic [PulseW-1:0]                  pulse_ff;

   assign pct_ext = {{(ProdW-tm_pkg::PctW){pct[tm_pkg::PctW-1]}}, pct};
   assign off     = pct_ext + ProdW'(tm_pkg::PctLimit);
   assign span    = $signed({{(ProdW-PulseW){1'b0}}, pulse_max})
                  - $signed({{(ProdW-PulseW){1'b0}}, pulse_min});
   assign prod_in = off * span;

   assign mag  = prod_ff[ProdW-1] ? ProdW'(-prod_ff) : prod_ff;
   assign x    = mag[tm_pkg::DivPreSh +: tm_pkg::DivInW];
   assign y_in = {{tm_pkg::RecipW{1'b0}}, x}
               * {{tm_pkg::DivInW{1'b0}}, tm_pkg::RecipW'(tm_pkg::Recip)};

   assign q = y_ff[tm_pkg::RecipShift +: PulseW];
   assign r = neg_ff ? -$signed({2'b00, q}) : $signed({2'b00, q});
   assign p = r + $signed({2'b00, pulse_min});

   always_comb begin
      if (suspend) begin
         pulse_in = pulse_neutral;
      end else if (p < 0) begin
         pulse_in = '0;
      end else if (p > SumW'(tm_pkg::PulseTop)) begin
         pulse_in = PulseW'(tm_pkg::PulseTop);
      end else begin
         pulse_in = p[PulseW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      y_ff     <= y_in;
      neg_ff   <= prod_ff[ProdW-1];
      pulse_ff <= pulse_in;
   end

   assign pulse = pulse_ff;

endmodule

// ===== tb/sv/mix_checker.sv =====
`timescale 1ns / 1ps

module mix_checker
   import tm_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic signed [StickW-1:0] req_stick_vertical,
   input  logic signed [StickW-1:0] req_stick_rotation,
   input  logic signed [StickW-1:0] req_stick_sideways,
   input  logic signed [StickW-1:0] req_stick_forward,
   input  logic                     csr_we,
   input  logic [CsrIndexW-1:0]     csr_index,
   input  logic [CsrDataW-1:0]      csr_wdata,
   input  logic                     rsp_strobe,
   input  logic [PulseW-1:0]        rsp_pulse_front_left,
   input  logic [PulseW-1:0]        rsp_pulse_front_right,
   input  logic [PulseW-1:0]        rsp_pulse_back_left,
   input  logic [PulseW-1:0]        rsp_pulse_back_right,
   input  logic [PulseW-1:0]        rsp_pulse_vertical_a,
   input  logic [PulseW-1:0]        rsp_pulse_vertical_b,
   input  logic                     rsp_light_on,
   output int                       mismatch_count,
   output int                       outstanding
);

   typedef struct packed {
      logic [GainW-1:0]  gain_fwd;
      logic [GainW-1:0]  gain_side;
      logic [GainW-1:0]  gain_rot;
      logic [CutW-1:0]   cutoff;
      logic [PulseW-1:0] pmin;
      logic [PulseW-1:0] pmax;
      logic [PulseW-1:0] pneutral;
      logic              suspend;
   } mixer_regs_type;

   // motor order: front left, front right, back left, back right, vertical a, vertical b
   typedef struct packed {
      logic [5:0][PulseW-1:0] pulse;
      logic                   light;
   } motor_set_type;

   localparam int FwdSign  [4] = '{1, -1, 1, -1};
   localparam int SideSign [4] = '{-1, -1, 1, 1};
   localparam int RotSign  [4] = '{-1, 1, 1, -1};
   localparam longint OneQ16   = 65536;
   localparam longint LimitQ16 = 100 * 65536;

   mixer_regs_type regs;
   motor_set_type  expected_q [$];

   function automatic longint motor_percent(input longint mix, input mixer_regs_type r,
                                            inout logic lit);
      longint m;
      m = mix;
      if (m > LimitQ16) m = LimitQ16;
      if (m < -LimitQ16) m = -LimitQ16;
      if ((m < 0 ? -m : m) < longint'(r.cutoff) * OneQ16) m = 0;
      if (m != 0) lit = 1'b1;
      return m / OneQ16;
   endfunction

   function automatic logic [PulseW-1:0] pulse_width(input longint pct,
                                                     input mixer_regs_type r);
      longint p;
      if (r.suspend) return r.pneutral;
      p = (pct + 100) * (longint'(r.pmax) - longint'(r.pmin)) / 200 + longint'(r.pmin);
      if (p < 0) p = 0;
      if (p > PulseTop) p = PulseTop;
      return p[PulseW-1:0];
   endfunction

   function automatic motor_set_type mix_sticks(input logic signed [StickW-1:0] vert,
                                                input logic signed [StickW-1:0] rot,
                                                input logic signed [StickW-1:0] side,
                                                input logic signed [StickW-1:0] fwd,
                                                input mixer_regs_type r);
      motor_set_type res;
      longint jf, js, jr, mag_sum, tf, ts, tr, n, h, vpct;
      logic lit;
      lit = 1'b0;
      jf = longint'(fwd);
      js = longint'(side);
      jr = longint'(rot);
      if (jf < 0) jf = -jf;
      if (js < 0) js = -js;
      if (jr < 0) jr = -jr;
      mag_sum = jf + js + jr;
      tf = longint'(fwd) * jf * longint'(r.gain_fwd);
      ts = longint'(side) * js * longint'(r.gain_side);
      tr = longint'(rot) * jr * longint'(r.gain_rot);
      for (int i = 0; i < 4; i++) begin
         h = 0;
         if (mag_sum != 0) begin
            n = FwdSign[i] * tf + SideSign[i] * ts + RotSign[i] * tr;
            h = (n * 256) / mag_sum;
         end
         res.pulse[i] = pulse_width(motor_percent(h, r, lit), r);
      end
      vpct = motor_percent(longint'(vert) * OneQ16, r, lit);
      res.pulse[4] = pulse_width(vpct, r);
      res.pulse[5] = res.pulse[4];
      res.light = lit;
      return res;
   endfunction

   always @(posedge clock) begin
      motor_set_type want;
      motor_set_type got;
      logic [6:0] bad;
      if (reset) begin
         expected_q.delete();
         regs.gain_fwd  = GainReset;
         regs.gain_side = GainReset;
         regs.gain_rot  = GainReset;
         regs.cutoff    = CutReset;
         regs.pmin      = PulseMinRst;
         regs.pmax      = PulseMaxRst;
         regs.pneutral  = PulseNeuRst;
         regs.suspend   = 1'b0;
         mismatch_count = 0;
         outstanding    = 0;
      end else begin
         if (rsp_strobe) begin
            got.pulse = {rsp_pulse_vertical_b, rsp_pulse_vertical_a, rsp_pulse_back_right,
                         rsp_pulse_back_left, rsp_pulse_front_right, rsp_pulse_front_left};
            got.light = rsp_light_on;
            if (expected_q.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with no item outstanding", $time);
            end else begin
               want = expected_q.pop_front();
               for (int k = 0; k < 6; k++)
                  bad[k] = got.pulse[k] !== want.pulse[k];
               bad[6] = got.light !== want.light;
               if (bad != '0) begin
                  mismatch_count++;
                  if (mismatch_count <= 10) begin
                     $display("%0t: mismatch fields %b", $time, bad);
                     $display("   expected FL %0d FR %0d BL %0d BR %0d VA %0d VB %0d light %b",
                              want.pulse[0], want.pulse[1], want.pulse[2], want.pulse[3],
                              want.pulse[4], want.pulse[5], want.light);
                     $display("   got      FL %0d FR %0d BL %0d BR %0d VA %0d VB %0d light %b",
                              got.pulse[0], got.pulse[1], got.pulse[2], got.pulse[3],
                              got.pulse[4], got.pulse[5], got.light);
                  end
               end
            end
         end
         if (start && !busy)
            expected_q.push_back(mix_sticks(req_stick_vertical, req_stick_rotation,
                                            req_stick_sideways, req_stick_forward, regs));
         if (csr_we) begin
            case (reg_index_type'(csr_index))
               RegGainForward:  regs.gain_fwd  = csr_wdata[GainW-1:0];
               RegGainSideways: regs.gain_side = csr_wdata[GainW-1:0];
               RegGainRotation: regs.gain_rot  = csr_wdata[GainW-1:0];
               RegZeroCutoff:   regs.cutoff    = csr_wdata[CutW-1:0];
               RegPulseMin:     regs.pmin      = csr_wdata[PulseW-1:0];
               RegPulseMax:     regs.pmax      = csr_wdata[PulseW-1:0];
               RegPulseNeutral: regs.pneutral  = csr_wdata[PulseW-1:0];
               RegSuspend:      regs.suspend   = csr_wdata[0];
               default: ;
            endcase
         end
         outstanding = expected_q.size();
      end
   end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import tm_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [StickW-1:0] req_stick_vertical = '0;
   logic signed [StickW-1:0] req_stick_rotation = '0;
   logic signed [StickW-1:0] req_stick_sideways = '0;
   logic signed [StickW-1:0] req_stick_forward  = '0;
   logic                     csr_we = 1'b0;
   logic [CsrIndexW-1:0]     csr_index = '0;
   logic [CsrDataW-1:0]      csr_wdata = '0;
   logic                     rsp_strobe;
   logic [PulseW-1:0]        rsp_pulse_front_left;
   logic [PulseW-1:0]        rsp_pulse_front_right;
   logic [PulseW-1:0]        rsp_pulse_back_left;
   logic [PulseW-1:0]        rsp_pulse_back_right;
   logic [PulseW-1:0]        rsp_pulse_vertical_a;
   logic [PulseW-1:0]        rsp_pulse_vertical_b;
   logic                     rsp_light_on;
   int                       mismatch_count;
   int                       outstanding;

   thruster_mixer u_dut (.*);

   mix_checker u_check (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #3_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic logic signed [StickW-1:0] rand_stick();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return '0;
      if (pick == 1) return StickW'($urandom_range(0, 255));
      if (pick == 2) return ($urandom_range(0, 1) == 1) ? StickW'(100) : StickW'(-100);
      return StickW'(int'($urandom_range(0, 200)) - 100);
   endfunction

   function automatic logic [CsrDataW-1:0] rand_val(input int lo, input int hi);
      return CsrDataW'($urandom_range(hi, lo));
   endfunction

   task automatic send_cmd(input logic signed [StickW-1:0] vert,
                           input logic signed [StickW-1:0] rot,
                           input logic signed [StickW-1:0] side,
                           input logic signed [StickW-1:0] fwd);
      start = 1'b1;
      req_stick_vertical = vert;
      req_stick_rotation = rot;
      req_stick_sideways = side;
      req_stick_forward  = fwd;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic settle();
      start = 1'b0;
      wait (outstanding == 0);
      @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CsrDataW-1:0] val);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = val;
      @(negedge clock);
   endtask

   task automatic program_regs(input logic [CsrDataW-1:0] gf, input logic [CsrDataW-1:0] gs,
                               input logic [CsrDataW-1:0] gr, input logic [CsrDataW-1:0] cut,
                               input logic [CsrDataW-1:0] pmin,
                               input logic [CsrDataW-1:0] pmax,
                               input logic [CsrDataW-1:0] pneu,
                               input logic [CsrDataW-1:0] susp);
      write_reg(RegGainForward, gf);
      write_reg(RegGainSideways, gs);
      write_reg(RegGainRotation, gr);
      write_reg(RegZeroCutoff, cut);
      write_reg(RegPulseMin, pmin);
      write_reg(RegPulseMax, pmax);
      write_reg(RegPulseNeutral, pneu);
      write_reg(RegSuspend, susp);
      csr_we = 1'b0;
   endtask

   task automatic run_random(input int count, input bit gaps);
      bit quiet;
      logic signed [StickW-1:0] v, r, s, f;
      quiet = 1'b0;
      for (int n = 0; n < count; n++) begin
         if (n % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
         if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
            start = 1'b0;
            req_stick_vertical = rand_stick();
            req_stick_rotation = rand_stick();
            req_stick_sideways = rand_stick();
            req_stick_forward  = rand_stick();
            repeat ($urandom_range(1, 14)) @(negedge clock);
         end
         v = rand_stick();
         r = rand_stick();
         s = rand_stick();
         f = rand_stick();
         if ($urandom_range(0, 15) == 0) begin
            r = '0;
            s = '0;
            f = '0;
         end
         send_cmd(v, r, s, f);
      end
      start = 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_cmd(0, 0, 0, 0);
      send_cmd(100, 100, 100, 100);
      send_cmd(-100, -100, -100, -100);
      send_cmd(127, 127, 127, 127);
      send_cmd(-128, -128, -128, -128);
      send_cmd(0, 0, 0, 100);
      send_cmd(0, 0, 0, -100);
      send_cmd(0, 0, 100, 0);
      send_cmd(0, 0, -100, 0);
      send_cmd(0, 100, 0, 0);
      send_cmd(0, -100, 0, 0);
      send_cmd(100, 0, 0, 0);
      send_cmd(-100, 0, 0, 0);
      send_cmd(50, 0, 0, 0);
      send_cmd(-7, 30, -60, 90);
      send_cmd(1, -1, 1, -1);
      send_cmd(85, 0, -128, 127);
      send_cmd(-128, 127, 0, -128);
      send_cmd(127, -128, 127, 0);
      start = 1'b0;

      for (int ph = 0; ph < 8; ph++) begin
         if (ph > 0) begin
            settle();
            case (ph)
               1: program_regs(12'hFFF, 12'hFFF, 12'hFFF, 0, 0, 4095, 0, 0);
               2: program_regs(0, 0, 0, 100, 4095, 0, 4095, 0);
               3, 6: program_regs(rand_val(0, 4095), rand_val(0, 4095),
                                  rand_val(0, 4095), rand_val(0, 4095),
                                  rand_val(0, 4095), rand_val(0, 4095),
                                  rand_val(0, 4095), rand_val(0, 4095));
               4: program_regs(256, 128, 512, 12'hF7F, 1100, 1900, 1500, 1);
               5: program_regs(rand_val(0, 1023), rand_val(0, 1023),
                               rand_val(0, 1023), rand_val(0, 20),
                               rand_val(0, 2000), rand_val(2000, 4095),
                               rand_val(0, 4095), 0);
               default: program_regs(256, 256, 256, 0, 1000, 2000, 1500, 0);
            endcase
         end
         run_random(212, ph < 7);
      end

      start = 1'b0;
      wait (outstanding == 0);
      repeat (25) @(negedge clock);
      if (mismatch_count == 0 && outstanding == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
